>>> rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator: item
// codes, status codes, divider sizing and the controller/datapath buses.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SAT     = 2'd1;
    localparam logic [1:0] ST_ZERO_W  = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    localparam logic [31:0] INT32_HI = 32'h7fff_ffff;
    localparam logic [31:0] INT32_LO = 32'h8000_0000;

    // numerator is 65 bits wide, one quotient bit per divider step
    localparam int NUM_W     = 65;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [NUM_W-1:0] Q_LIMIT = NUM_W'(1) << 34;

    typedef struct packed {
        logic load_x;
        logic cap_prev;
        logic cap_a;
        logic cap_b;
        logic mul;
        logic num;
        logic div_step;
        logic finish;
        logic set_one;
        logic set_zero_w;
        logic set_nomatch;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic x_lt_rd;
        logic x_gt_rd;
        logic in_seg;
        logic dw_zero;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with linear interpolation and end-segment extrapolation,
// signed Q16.16, saturating, with a status code per query.
// Load: taken into the table at the transfer, no result.
// Query: the first x and then the last x are checked, else the table is scanned
//   for the segment; with one point in use its y is returned as it stands.
//   A 65-step restoring divider computes the interpolation; the search reads one x a cycle.
// One query at a time; the next item is taken once the result is registered.
// Reset sets points_in_use to 2 and empties the output; the table is not cleared.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [3:0]  i_point_index,
    input  logic [31:0] i_x_value,
    input  logic [31:0] i_y_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_y_result,
    output logic [1:0]  o_status
);
    import pli_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_x;
    logic [31:0]   rd_y;

    pli_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_point_index(i_point_index),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    pli_ram #(
        .WIDTH(32),
        .DEPTH(MAX_POINTS)
    ) u_ram_x (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(i_x_value),
        .i_raddr(rd_addr),
        .o_rdata(rd_x)
    );

    pli_ram #(
        .WIDTH(32),
        .DEPTH(MAX_POINTS)
    ) u_ram_y (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(i_y_value),
        .i_raddr(rd_addr),
        .o_rdata(rd_y)
    );

    pli_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_x_value  (i_x_value),
        .i_rd_x     (rd_x),
        .i_rd_y     (rd_y),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_y_result (o_y_result),
        .o_status   (o_status)
    );

endmodule

>>> rtl/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pli_dp.sv
// ----------------------------------------------------------------------------
// pli_dp
// Datapath: query and segment registers, differences and magnitudes, one
// 32x32 multiply, restoring divider with rounding, saturation and the
// output register.
// ----------------------------------------------------------------------------
module pli_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pli_pkg::t_dp_cmd i_cmd,
    output pli_pkg::t_dp_sts o_sts,
    input  logic [31:0]      i_x_value,
    input  logic [31:0]      i_rd_x,
    input  logic [31:0]      i_rd_y,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [31:0]      o_y_result,
    output logic [1:0]       o_status
);
    import pli_pkg::*;

    function automatic logic [31:0] mag33(input logic [32:0] v);
        logic [32:0] neg_v;
        neg_v = -v;
        return v[32] ? neg_v[31:0] : v[31:0];
    endfunction

    logic [31:0]      r_x;
    logic [31:0]      r_prev;
    logic [31:0]      r_xa;
    logic [31:0]      r_ya;
    logic [31:0]      r_dx_mag;
    logic [31:0]      r_dy_mag;
    logic [31:0]      r_dw_mag;
    logic             r_neg;
    logic             r_dw_zero;
    logic [63:0]      r_prod;
    logic [NUM_W-1:0] r_num;
    logic [31:0]      r_rem;
    logic [31:0]      r_res_y;
    logic [1:0]       r_res_st;
    logic             r_out_valid;
    logic [31:0]      r_out_y;
    logic [1:0]       r_out_st;

    logic [32:0]      dx;
    logic [32:0]      dw;
    logic [32:0]      dy;
    logic [32:0]      cand;
    logic [33:0]      trial;
    logic             ge;
    logic             q_sat;
    logic             neg_eff;
    logic [36:0]      ya37;
    logic [36:0]      q37;
    logic [36:0]      sum37;
    logic [31:0]      fin_y;
    logic [1:0]       fin_st;
    logic             out_free;

    // segment differences, taken while the far end is on the read port
    assign dx = {r_x[31], r_x} - {r_xa[31], r_xa};
    assign dw = {i_rd_x[31], i_rd_x} - {r_xa[31], r_xa};
    assign dy = {i_rd_y[31], i_rd_y} - {r_ya[31], r_ya};

    // one restoring division step
    assign cand  = {r_rem, r_num[NUM_W-1]};
    assign trial = {1'b0, cand} - {2'b00, r_dw_mag};
    assign ge    = !trial[33];

    always_comb begin
        q_sat   = r_num > Q_LIMIT;
        neg_eff = r_neg && (r_num != '0);
        ya37    = {{5{r_ya[31]}}, r_ya};
        q37     = {2'b00, r_num[34:0]};
        sum37   = neg_eff ? (ya37 - q37) : (ya37 + q37);
        if (q_sat) begin
            fin_y  = neg_eff ? INT32_LO : INT32_HI;
            fin_st = ST_SAT;
        end else if ($signed(sum37) > $signed({5'b00000, INT32_HI})) begin
            fin_y  = INT32_HI;
            fin_st = ST_SAT;
        end else if ($signed(sum37) < $signed({5'b11111, INT32_LO})) begin
            fin_y  = INT32_LO;
            fin_st = ST_SAT;
        end else begin
            fin_y  = sum37[31:0];
            fin_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_x_value;
        end
        if (i_cmd.cap_prev) begin
            r_prev <= i_rd_x;
        end
        if (i_cmd.cap_a) begin
            r_xa <= i_rd_x;
            r_ya <= i_rd_y;
        end
        if (i_cmd.cap_b) begin
            r_dx_mag  <= mag33(dx);
            r_dy_mag  <= mag33(dy);
            r_dw_mag  <= mag33(dw);
            r_neg     <= dx[32] ^ dy[32] ^ dw[32];
            r_dw_zero <= (dw == '0);
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_dx_mag) * 64'(r_dy_mag);
        end
        if (i_cmd.num) begin
            // round to nearest by adding half the divisor
            r_num <= {1'b0, r_prod} + {34'd0, r_dw_mag[31:1]};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? trial[31:0] : cand[31:0];
        end
        if (i_cmd.set_one) begin
            r_res_y  <= i_rd_y;
            r_res_st <= ST_OK;
        end else if (i_cmd.set_zero_w) begin
            r_res_y  <= '0;
            r_res_st <= ST_ZERO_W;
        end else if (i_cmd.set_nomatch) begin
            r_res_y  <= '0;
            r_res_st <= ST_NOMATCH;
        end else if (i_cmd.finish) begin
            r_res_y  <= fin_y;
            r_res_st <= fin_st;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_y  <= r_res_y;
            r_out_st <= r_res_st;
        end
    end

    always_comb begin
        o_sts.x_lt_rd  = $signed(r_x) < $signed(i_rd_x);
        o_sts.x_gt_rd  = $signed(r_x) > $signed(i_rd_x);
        o_sts.in_seg   = ($signed(r_prev) <= $signed(r_x)) && ($signed(r_x) <= $signed(i_rd_x));
        o_sts.dw_zero  = r_dw_zero;
        o_sts.out_free = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_y_result  = r_out_y;
    assign o_status    = r_out_st;

endmodule

>>> rtl/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Controller: points-in-use register, table write decode, breakpoint search
// sequencer and divider step counter.
// ----------------------------------------------------------------------------
module pli_ctrl #(
    parameter int MAX_POINTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [4:0]                    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [3:0]                    i_point_index,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_POINTS)-1:0] o_wr_addr,
    output logic [$clog2(MAX_POINTS)-1:0] o_rd_addr,
    output pli_pkg::t_dp_cmd              o_cmd,
    input  pli_pkg::t_dp_sts              i_sts
);
    import pli_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ONE       = 4'd1;
    localparam logic [3:0] S_CHK_FIRST = 4'd2;
    localparam logic [3:0] S_CHK_LAST  = 4'd3;
    localparam logic [3:0] S_SCAN      = 4'd4;
    localparam logic [3:0] S_SEG0      = 4'd5;
    localparam logic [3:0] S_SEG1      = 4'd6;
    localparam logic [3:0] S_SEG2      = 4'd7;
    localparam logic [3:0] S_MUL       = 4'd8;
    localparam logic [3:0] S_NUM       = 4'd9;
    localparam logic [3:0] S_DIV       = 4'd10;
    localparam logic [3:0] S_FIN       = 4'd11;
    localparam logic [3:0] S_DONE      = 4'd12;

    logic [4:0]       r_points;
    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [AW-1:0]    r_k;
    logic [AW-1:0]    n_k;
    logic [AW-1:0]    r_seg;
    logic [AW-1:0]    n_seg;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic [31:0]      pts32;
    logic [31:0]      n32;
    logic [31:0]      last32;
    logic [31:0]      slot32;
    logic [AW-1:0]    last;
    logic             one_pt;
    logic             in_stall;
    logic             in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= 5'd2;
        end else if (i_cfg_we) begin
            r_points <= i_cfg_wdata;
        end
    end

    // clamp the point count to 1..MAX_POINTS
    always_comb begin
        pts32 = 32'(r_points);
        if (pts32 == 32'd0) begin
            n32 = 32'd1;
        end else if (pts32 > 32'(MAX_POINTS)) begin
            n32 = 32'(MAX_POINTS);
        end else begin
            n32 = pts32;
        end
        last32 = n32 - 32'd1;
        last   = last32[AW-1:0];
        one_pt = (n32 == 32'd1);
    end

    assign in_stall = (r_state != S_IDLE);
    assign in_xfer  = i_in_valid && !in_stall;

    assign slot32    = 32'(i_point_index);
    assign o_wr_en   = in_xfer && (i_func == FUNC_LOAD) && (slot32 < 32'(MAX_POINTS));
    assign o_wr_addr = slot32[AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_seg     = r_seg;
        n_cnt     = r_cnt;
        o_cmd     = '0;
        o_rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_func == FUNC_QUERY)) begin
                    o_cmd.load_x = 1'b1;
                    n_state      = one_pt ? S_ONE : S_CHK_FIRST;
                end
            end
            S_ONE: begin
                o_cmd.set_one = 1'b1;
                n_state       = S_DONE;
            end
            S_CHK_FIRST: begin
                o_cmd.cap_prev = 1'b1;
                if (i_sts.x_lt_rd) begin
                    n_seg   = '0;
                    n_state = S_SEG0;
                end else begin
                    o_rd_addr = last;
                    n_state   = S_CHK_LAST;
                end
            end
            S_CHK_LAST: begin
                if (i_sts.x_gt_rd) begin
                    n_seg   = last - AW'(1);
                    n_state = S_SEG0;
                end else begin
                    o_rd_addr = AW'(1);
                    n_k       = AW'(1);
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.in_seg) begin
                    n_seg   = r_k - AW'(1);
                    n_state = S_SEG0;
                end else if (r_k == last) begin
                    o_cmd.set_nomatch = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.cap_prev = 1'b1;
                    n_k            = r_k + AW'(1);
                    o_rd_addr      = r_k + AW'(1);
                end
            end
            S_SEG0: begin
                o_rd_addr = r_seg;
                n_state   = S_SEG1;
            end
            S_SEG1: begin
                o_rd_addr   = r_seg + AW'(1);
                o_cmd.cap_a = 1'b1;
                n_state     = S_SEG2;
            end
            S_SEG2: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                if (i_sts.dw_zero) begin
                    o_cmd.set_zero_w = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_NUM;
                end
            end
            S_NUM: begin
                o_cmd.num = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_seg   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_seg   <= n_seg;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = in_stall;

endmodule
